// File: hdl/triggered_ring_trace_capture_top_macros.svh
// ----------------------------------------------------------------------------
// Triggered ring trace capture - assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_RING_TRACE_CAPTURE_TOP_MACROS_SVH
`define TRIGGERED_RING_TRACE_CAPTURE_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TRTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define TRTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/trtc_pkg.sv
// ----------------------------------------------------------------------------
// Triggered ring trace capture - package
// Sizes, codes, item layouts and channel helpers shared by the design.
// ----------------------------------------------------------------------------
package trtc_pkg;

    localparam int PARTS    = 8;
    localparam int PORTS    = 4;
    localparam int JOINTS   = 8;
    localparam int DEPTH    = 1024;
    localparam int CHANNELS = PARTS * PORTS * JOINTS;
    localparam int TOTAL_ENTRIES = CHANNELS * DEPTH;

    localparam int PART_W  = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int PORT_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int JOINT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int ADDR_W  = $clog2(TOTAL_ENTRIES);

    localparam int ENTRY_W = 33;
    localparam logic [ENTRY_W-1:0] NODATA_ENTRY = {1'b1, 32'hFFFF_0000};

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [2:0] ACT_SAMPLE  = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_FREEZE  = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PARTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORTS_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOINTS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POST_DELAY    = 2'd3;

    typedef struct packed {
        logic [9:0]         read_age;
        logic [7:0]         error_flags;
        logic signed [31:0] sample_value;
        logic [2:0]         joint;
        logic [1:0]         port;
        logic [2:0]         part;
    } trtc_item_t;

    localparam int ITEM_W = $bits(trtc_item_t);

    typedef struct packed {
        logic               status;
        logic [2:0]         trigger_part;
        logic               triggered;
        logic               frozen;
        logic               no_data;
        logic signed [31:0] read_value;
    } trtc_result_t;

    localparam int RES_W = $bits(trtc_result_t);

    typedef struct packed {
        logic              start;
        logic              clear_all;
        logic              set_en;
        logic [CHAN_W-1:0] set_chan;
    } trtc_flag_req_t;

    typedef struct packed {
        logic              wr_en;
        logic [CHAN_W-1:0] chan;
        logic              done;
    } trtc_sweep_t;

    function automatic logic part_enabled(input logic [7:0] mask, input logic [2:0] p);
        return (int'(p) < PARTS) && mask[p];
    endfunction

    function automatic int ports_used(input logic [2:0] n);
        return (int'(n) > PORTS) ? PORTS : int'(n);
    endfunction

    function automatic int joints_used(input logic [3:0] n);
        return (int'(n) > JOINTS) ? JOINTS : int'(n);
    endfunction

endpackage

// File: hdl/trtc_sweep.sv
// ----------------------------------------------------------------------------
// Triggered ring trace capture - period flags and channel walk
// Tracks which channels got a sample this period and walks the channel
// positions at period end, naming each in-use one that still needs a no-data mark.
// ----------------------------------------------------------------------------
module trtc_sweep (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  trtc_pkg::trtc_flag_req_t req,
    input  logic [7:0]              active_parts,
    input  logic [2:0]              ports_in_use,
    input  logic [3:0]              joints_in_use,
    output trtc_pkg::trtc_sweep_t   sweep
);
    import trtc_pkg::*;

    logic [CHANNELS-1:0] written_reg;
    logic                active_reg;
    logic [PART_W-1:0]   part_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [JOINT_W-1:0]  joint_reg;

    logic              last_joint;
    logic              last_port;
    logic              last_part;
    logic              in_use;
    logic [CHAN_W-1:0] chan;

    always_comb begin
        last_joint = (int'(joint_reg) + 1) >= joints_used(joints_in_use);
        last_port  = (int'(port_reg) + 1) >= ports_used(ports_in_use);
        last_part  = int'(part_reg) == PARTS - 1;
        chan       = CHAN_W'((int'(part_reg) * PORTS + int'(port_reg)) * JOINTS
                             + int'(joint_reg));
        in_use     = part_enabled(active_parts, 3'(part_reg))
                     && (int'(port_reg) < ports_used(ports_in_use))
                     && (int'(joint_reg) < joints_used(joints_in_use));
        sweep.wr_en = active_reg && in_use && !written_reg[chan];
        sweep.chan  = chan;
        sweep.done  = active_reg && last_joint && last_port && last_part;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            active_reg  <= 1'b0;
            part_reg    <= '0;
            port_reg    <= '0;
            joint_reg   <= '0;
        end else begin
            if (req.clear_all) begin
                written_reg <= '0;
            end else if (req.set_en) begin
                written_reg[req.set_chan] <= 1'b1;
            end
            if (req.start) begin
                active_reg <= 1'b1;
                part_reg   <= '0;
                port_reg   <= '0;
                joint_reg  <= '0;
            end else if (active_reg) begin
                if (last_joint) begin
                    joint_reg <= '0;
                    if (last_port) begin
                        port_reg <= '0;
                        if (last_part) begin
                            active_reg <= 1'b0;
                            part_reg   <= '0;
                        end else begin
                            part_reg <= part_reg + 1'b1;
                        end
                    end else begin
                        port_reg <= port_reg + 1'b1;
                    end
                end else begin
                    joint_reg <= joint_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: hdl/triggered_ring_trace_capture_top.sv
// ----------------------------------------------------------------------------
// Triggered ring trace capture - top level
// Circular per-channel trace store with error trigger, post-trigger delay,
// manual freeze, restart and oldest-first readout.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives one result. Sample, manual
// freeze, restart, a rejected item and a tick that freezes capture answer
// from the idle state; a read waits in ST_READ for the registered memory
// read. A period-advancing tick walks every (part, port, joint) position of
// all parts within the configured counts and writes no-data marks for in-use
// channels with no sample this period through the single memory port. The
// trace memory (262144 x 33) is never cleared; only entries written since
// power-up read back defined data. Per-channel period flags live in flip-flops.
// ----------------------------------------------------------------------------
module triggered_ring_trace_capture_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // part, port, joint, sample_value, error_flags, read_age, zero fill
    input  logic [trtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [trtc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value, no_data, frozen, triggered, trigger_part, status, zero fill
    output logic [trtc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trtc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import trtc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  active_parts_reg;
    logic [2:0]  ports_in_use_reg;
    logic [3:0]  joints_in_use_reg;
    logic [15:0] post_delay_reg;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic              armed_reg, armed_next;
    logic [2:0]        armed_part_reg, armed_part_next;
    logic [15:0]       delay_reg, delay_next;
    logic              stopped_reg, stopped_next;

    logic         m_valid_reg, m_valid_next;
    trtc_result_t m_data_reg, m_data_next;

    logic [ENTRY_W-1:0] trace_mem [TOTAL_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    trtc_item_t     item;
    logic [2:0]     action;
    logic           accept;
    logic           chan_ok;
    logic [CHAN_W-1:0] item_chan;
    logic           arm_hit;
    logic [2:0]     arm_part;
    logic [15:0]    delay_sat;
    logic [SLOT_W-1:0] read_slot;
    trtc_flag_req_t flag_req;
    trtc_sweep_t    sweep;

    assign cfg_ready = 1'b1;
    assign item      = trtc_item_t'(s_tdata[ITEM_W-1:0]);
    assign action    = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {(M_TDATA_W - RES_W)'(0), m_data_reg};

    trtc_sweep u_sweep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (flag_req),
        .active_parts  (active_parts_reg),
        .ports_in_use  (ports_in_use_reg),
        .joints_in_use (joints_in_use_reg),
        .sweep         (sweep)
    );

    always_comb begin
        int rs;
        chan_ok   = part_enabled(active_parts_reg, item.part)
                    && (int'(item.port) < ports_used(ports_in_use_reg))
                    && (int'(item.joint) < joints_used(joints_in_use_reg));
        item_chan = CHAN_W'((int'(item.part) * PORTS + int'(item.port)) * JOINTS
                            + int'(item.joint));
        arm_hit  = 1'b0;
        arm_part = armed_part_reg;
        for (int p = 0; p < PARTS; p++) begin
            if (active_parts_reg[p] && item.error_flags[p]) begin
                arm_hit  = 1'b1;
                arm_part = 3'(p);
            end
        end
        delay_sat = (delay_reg == 16'hFFFF) ? delay_reg : delay_reg + 16'd1;
        rs = int'(write_slot_reg) + int'(item.read_age);
        if (rs >= DEPTH) begin
            rs = rs - DEPTH;
        end
        read_slot = SLOT_W'(rs);
    end

    always_comb begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        armed_next      = armed_reg;
        armed_part_next = armed_part_reg;
        delay_next      = delay_reg;
        stopped_next    = stopped_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = ADDR_W'(int'(item_chan) * DEPTH + int'(write_slot_reg));
        mem_wdata       = {1'b0, item.sample_value};
        flag_req        = '0;
        flag_req.set_chan = item_chan;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_data_next.status     = 1'b1;
                    m_data_next.read_value = '0;
                    m_data_next.no_data    = 1'b0;
                    case (action)
                        ACT_SAMPLE: begin
                            if (!stopped_reg && chan_ok) begin
                                mem_we          = 1'b1;
                                flag_req.set_en = 1'b1;
                                m_data_next.status = 1'b0;
                            end
                        end
                        ACT_TICK: begin
                            if (!stopped_reg) begin
                                if (!armed_reg) begin
                                    armed_next      = arm_hit;
                                    armed_part_next = arm_part;
                                    flag_req.start  = 1'b1;
                                    state_next      = ST_SWEEP;
                                end else begin
                                    delay_next = delay_sat;
                                    if (delay_sat > post_delay_reg) begin
                                        stopped_next       = 1'b1;
                                        flag_req.clear_all = 1'b1;
                                        m_data_next.status = 1'b0;
                                    end else begin
                                        flag_req.start = 1'b1;
                                        state_next     = ST_SWEEP;
                                    end
                                end
                            end
                        end
                        ACT_FREEZE: begin
                            if (!stopped_reg && part_enabled(active_parts_reg, item.part)) begin
                                stopped_next       = 1'b1;
                                armed_part_next    = item.part;
                                flag_req.clear_all = 1'b1;
                                m_data_next.status = 1'b0;
                            end
                        end
                        ACT_READ: begin
                            if (chan_ok && (int'(item.read_age) < DEPTH)) begin
                                mem_re     = 1'b1;
                                mem_addr   = ADDR_W'(int'(item_chan) * DEPTH
                                                     + int'(read_slot));
                                state_next = ST_READ;
                            end
                        end
                        ACT_RESTART: begin
                            stopped_next       = 1'b0;
                            armed_next         = 1'b0;
                            armed_part_next    = '0;
                            delay_next         = '0;
                            write_slot_next    = '0;
                            flag_req.clear_all = 1'b1;
                            m_data_next.status = 1'b0;
                        end
                        default: ;
                    endcase
                    m_data_next.frozen       = stopped_next;
                    m_data_next.triggered    = armed_next;
                    m_data_next.trigger_part = armed_part_next;
                    m_valid_next             = (state_next == ST_IDLE);
                end
            end
            ST_READ: begin
                m_data_next.read_value = rd_data_reg[31:0];
                m_data_next.no_data    = rd_data_reg[32];
                m_data_next.status     = 1'b0;
                m_valid_next           = 1'b1;
                state_next             = ST_IDLE;
            end
            ST_SWEEP: begin
                mem_we    = sweep.wr_en;
                mem_addr  = ADDR_W'(int'(sweep.chan) * DEPTH + int'(write_slot_reg));
                mem_wdata = NODATA_ENTRY;
                if (sweep.done) begin
                    flag_req.clear_all = 1'b1;
                    write_slot_next    = (write_slot_reg == SLOT_W'(DEPTH - 1))
                                         ? '0 : write_slot_reg + 1'b1;
                    m_data_next.status     = 1'b0;
                    m_data_next.read_value = '0;
                    m_data_next.no_data    = 1'b0;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            trace_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= trace_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            active_parts_reg  <= '0;
            ports_in_use_reg  <= 3'd1;
            joints_in_use_reg <= 4'd1;
            post_delay_reg    <= '0;
            write_slot_reg    <= '0;
            armed_reg         <= 1'b0;
            armed_part_reg    <= '0;
            delay_reg         <= '0;
            stopped_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            armed_reg      <= armed_next;
            armed_part_reg <= armed_part_next;
            delay_reg      <= delay_next;
            stopped_reg    <= stopped_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ACTIVE_PARTS:  active_parts_reg  <= cfg_data[7:0];
                    REG_PORTS_IN_USE:  ports_in_use_reg  <= cfg_data[2:0];
                    REG_JOINTS_IN_USE: joints_in_use_reg <= cfg_data[3:0];
                    REG_POST_DELAY:    post_delay_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: hdl/trtc_checker.sv
// ----------------------------------------------------------------------------
// Triggered ring trace capture - port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
`include "triggered_ring_trace_capture_top_macros.svh"

module trtc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [trtc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [trtc_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [trtc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [trtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [trtc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import trtc_pkg::*;

    trtc_result_t res;
    assign res = trtc_result_t'(m_tdata[RES_W-1:0]);

    `TRTC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `TRTC_ASSERT_NOW(a_no_take_on_stall, m_tvalid && !m_tready, !s_tready, "item taken while result stalled")
    `TRTC_ASSERT_NOW(a_reject_clean, m_tvalid && res.status, (res.read_value == 32'sd0) && !res.no_data, "rejected item carries read data")
    `TRTC_ASSERT_NOW(a_part_idle, m_tvalid && !res.frozen && !res.triggered, res.trigger_part == 3'd0, "trigger part set without trigger or freeze")

endmodule

bind triggered_ring_trace_capture_top trtc_checker u_trtc_checker (.*);
